### src/sfp_pkg.sv
// sfp_pkg: types and constants shared by the servo status frame parser
// used by sfp_frame_core and servo_feedback_frame_parser; no dependencies
`timescale 1ns / 1ps

package sfp_pkg;

   localparam int unsigned FrameLen = 21;
   localparam int unsigned SumEnd   = 20;
   localparam int unsigned CapDepth = 18;
   localparam int unsigned PosW     = 5;
   localparam int unsigned CapIdxW  = $clog2(CapDepth);

   localparam logic [7:0]      HDR_BYTE  = 8'hFF;
   localparam logic [PosW-1:0] POS_IDLE  = PosW'(FrameLen);
   localparam logic [PosW-1:0] POS_HDR2  = PosW'(1);
   localparam logic [PosW-1:0] POS_FIRST = PosW'(2);
   localparam logic [PosW-1:0] POS_CSUM  = PosW'(SumEnd);

   typedef struct packed {
      logic [7:0]  servo_id;
      logic [15:0] angle_now;
      logic [15:0] speed_now;
      logic [15:0] load_now;
      logic [7:0]  voltage_now;
      logic [7:0]  temperature_now;
      logic [7:0]  pending_write;
      logic [7:0]  error_bits;
      logic [7:0]  moving_flag;
      logic [15:0] target_angle_now;
      logic [15:0] current_now;
   } meas_type;

   typedef struct packed {
      logic done;
      logic ok;
   } frame_status_type;

endpackage

### src/servo_feedback_frame_parser.sv
// servo_feedback_frame_parser: top level, input beat register, held fields, result register
// depends on sfp_pkg and sfp_frame_core
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | rx_byte, frame_start
//   rsp     | out       | rsp_valid/rsp_ready  | frame_ok and eleven measurement fields
//
// one byte accepted per cycle unless a stalled result holds the input register;
// a byte is processed from the input register, and a frame's result is registered for rsp
// reset: idle waiting for a start, held fields zero, no beat pending
// a stalled result holds only a frame-ending byte in the input register;
// all other bytes keep flowing
`timescale 1ns / 1ps

module servo_feedback_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_ok,
   output logic [7:0]  rsp_servo_id,
   output logic [15:0] rsp_angle_now,
   output logic [15:0] rsp_speed_now,
   output logic [15:0] rsp_load_now,
   output logic [7:0]  rsp_voltage_now,
   output logic [7:0]  rsp_temperature_now,
   output logic [7:0]  rsp_pending_write,
   output logic [7:0]  rsp_error_bits,
   output logic [7:0]  rsp_moving_flag,
   output logic [15:0] rsp_target_angle_now,
   output logic [15:0] rsp_current_now
);
   import sfp_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_start_ff;
   logic             advance;
   logic             load_rsp;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             frame_ok_ff, frame_ok_in;
   meas_type         held_ff, held_in;
   meas_type         cap_meas;
   frame_status_type status;

   sfp_frame_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .status      (status),
      .cap_meas    (cap_meas)
   );

   assign advance   = in_valid_ff && (!status.done || !rsp_valid_ff || rsp_ready);
   assign load_rsp  = advance && status.done;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_valid || (in_valid_ff && !advance);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      frame_ok_in  = frame_ok_ff;
      held_in      = held_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         frame_ok_in  = status.ok;
         if (status.ok) begin
            held_in = cap_meas;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ok_ff <= frame_ok_in;
      if (req_ready) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_ok         = frame_ok_ff;
   assign rsp_servo_id         = held_ff.servo_id;
   assign rsp_angle_now        = held_ff.angle_now;
   assign rsp_speed_now        = held_ff.speed_now;
   assign rsp_load_now         = held_ff.load_now;
   assign rsp_voltage_now      = held_ff.voltage_now;
   assign rsp_temperature_now  = held_ff.temperature_now;
   assign rsp_pending_write    = held_ff.pending_write;
   assign rsp_error_bits       = held_ff.error_bits;
   assign rsp_moving_flag      = held_ff.moving_flag;
   assign rsp_target_angle_now = held_ff.target_angle_now;
   assign rsp_current_now      = held_ff.current_now;

   // a new result never lands on a beat still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending beat");

   // a bad frame leaves the held fields alone
   a_bad_keeps: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && !status.ok) |=> (held_ff == $past(held_ff)))
      else $error("held fields changed on a bad frame");

   // a good frame takes its fields from the capture store
   a_good_loads: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && status.ok) |=> (held_ff == $past(cap_meas) && frame_ok_ff))
      else $error("held fields not loaded on a good frame");

endmodule

### src/sfp_frame_core.sv
// sfp_frame_core: byte position, header check, running sum and capture store
// of one status frame; depends on sfp_pkg
`timescale 1ns / 1ps

module sfp_frame_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                rx_byte,
   input  logic                      frame_start,
   output sfp_pkg::frame_status_type status,
   output sfp_pkg::meas_type         cap_meas
);
   import sfp_pkg::*;

   logic [PosW-1:0] pos_ff, pos_in;
   logic [7:0]      sum_ff, sum_in;
   logic            hdr_ff, hdr_in;
   logic [7:0]      cap_ff [CapDepth];
   logic            cap_we;
   logic [CapIdxW-1:0] cap_idx;
   logic [PosW-1:0]    cap_off;

   assign cap_off = pos_ff - POS_FIRST;
   assign cap_idx = cap_off[CapIdxW-1:0];

   always_comb begin
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      hdr_in      = hdr_ff;
      cap_we      = 1'b0;
      status.done = !frame_start && (pos_ff == POS_CSUM);
      status.ok   = hdr_ff && (~sum_ff == rx_byte);
      if (step) begin
         if (frame_start) begin
            sum_in = 8'd0;
            hdr_in = (rx_byte == HDR_BYTE);
            pos_in = POS_HDR2;
         end else if (pos_ff >= POS_IDLE) begin
            pos_in = pos_ff;
         end else if (pos_ff == POS_HDR2) begin
            hdr_in = hdr_ff && (rx_byte == HDR_BYTE);
            pos_in = POS_FIRST;
         end else if (pos_ff < POS_CSUM) begin
            cap_we = 1'b1;
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + PosW'(1);
         end else begin
            pos_in = POS_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_IDLE;
         sum_ff <= 8'd0;
         hdr_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         hdr_ff <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_ff[cap_idx] <= rx_byte;
      end
   end

   // capture slot k holds frame byte k+2
   always_comb begin
      cap_meas.servo_id         = cap_ff[0];
      cap_meas.angle_now        = {cap_ff[4], cap_ff[3]};
      cap_meas.speed_now        = {cap_ff[6], cap_ff[5]};
      cap_meas.load_now         = {cap_ff[8], cap_ff[7]};
      cap_meas.voltage_now      = cap_ff[9];
      cap_meas.temperature_now  = cap_ff[10];
      cap_meas.pending_write    = cap_ff[11];
      cap_meas.error_bits       = cap_ff[12];
      cap_meas.moving_flag      = cap_ff[13];
      cap_meas.target_angle_now = {cap_ff[15], cap_ff[14]};
      cap_meas.current_now      = {cap_ff[17], cap_ff[16]};
   end

endmodule
